[sv/assert_macros.svh]
// Assertion macros shared by the nearest ray/sphere hit RTL.
// Needs signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define NRSH_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("nrsh: implication check failed");

// pre holds -> post holds in the next cycle
`define NRSH_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("nrsh: next-cycle check failed");

`endif

[sv/nrsh_pkg.sv]
// Package for the nearest ray/sphere hit block: widths, codes, types.
// No dependencies.
package nrsh_pkg;

   localparam int MaxSpheres = 16;
   localparam int FracBits   = 16;
   localparam int CountW     = 5;
   localparam int SlotW      = 4;
   localparam int CoordW     = 32;
   localparam int DiamW      = 31;
   localparam int TintW      = 24;
   localparam int DistW      = 31;
   localparam int OpW        = 64;
   localparam int ProdW      = 128;
   localparam int SumW       = 72;
   localparam int RootW      = 60;
   localparam int RadW       = 2 * RootW;
   localparam int DigitW     = 16;
   localparam int Digits     = OpW / DigitW;

   localparam logic [DistW-1:0] DistMax = '1;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_TRACE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_MUL, S_ABC, S_DISC, S_SQRT, S_ROOT, S_DIVST,
      S_DIV, S_DIVDONE, S_CMP, S_NEXT, S_FINAL, S_FRD, S_POST, S_OUT
   } state_type;

   typedef struct packed {
      logic signed [CoordW-1:0] cx;
      logic signed [CoordW-1:0] cy;
      logic signed [CoordW-1:0] cz;
      logic [DiamW-1:0]         diameter;
      logic [TintW-1:0]         tint;
   } entry_type;

   typedef struct packed {
      logic                  start;
      logic signed [OpW-1:0] op_a;
      logic signed [OpW-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ProdW-1:0] prod;
   } mul_rsp_type;

endpackage

[sv/nrsh_if.sv]
// Valid/ready channel interfaces of the nearest ray/sphere hit block.
// Depends on nrsh_pkg.
interface nrsh_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic [nrsh_pkg::SlotW-1:0]         slot;
   logic signed [nrsh_pkg::CoordW-1:0] pos_x;
   logic signed [nrsh_pkg::CoordW-1:0] pos_y;
   logic signed [nrsh_pkg::CoordW-1:0] pos_z;
   logic signed [nrsh_pkg::CoordW-1:0] dir_x;
   logic signed [nrsh_pkg::CoordW-1:0] dir_y;
   logic signed [nrsh_pkg::CoordW-1:0] dir_z;
   logic [nrsh_pkg::DiamW-1:0]         diameter;
   logic [nrsh_pkg::TintW-1:0]         tint;
   modport source (output valid, func, slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                   diameter, tint, input ready);
   modport sink (input valid, func, slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                 diameter, tint, output ready);
endinterface

interface nrsh_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic [nrsh_pkg::DistW-1:0]         hit_distance;
   logic [nrsh_pkg::TintW-1:0]         hit_colour;
   logic signed [nrsh_pkg::CoordW-1:0] point_x;
   logic signed [nrsh_pkg::CoordW-1:0] point_y;
   logic signed [nrsh_pkg::CoordW-1:0] point_z;
   logic signed [nrsh_pkg::CoordW-1:0] normal_x;
   logic signed [nrsh_pkg::CoordW-1:0] normal_y;
   logic signed [nrsh_pkg::CoordW-1:0] normal_z;
   modport source (output valid, hit, hit_distance, hit_colour, point_x, point_y, point_z,
                   normal_x, normal_y, normal_z, input ready);
   modport sink (input valid, hit, hit_distance, hit_colour, point_x, point_y, point_z,
                 normal_x, normal_y, normal_z, output ready);
endinterface

interface nrsh_csr_if;
   logic                        valid;
   logic                        ready;
   logic [nrsh_pkg::CountW-1:0] sphere_count;
   modport source (output valid, sphere_count, input ready);
   modport sink (input valid, sphere_count, output ready);
endinterface

[sv/nrsh_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module nrsh_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/nrsh_mul.sv]
// Multicycle signed 64x64 multiplier, one 16-bit digit of B per cycle.
// Depends on nrsh_pkg.
module nrsh_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  nrsh_pkg::mul_req_type req,
   output nrsh_pkg::mul_rsp_type rsp
);

   localparam int CntW = (nrsh_pkg::Digits > 1) ? $clog2(nrsh_pkg::Digits) : 1;

   logic [nrsh_pkg::OpW-1:0]   mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic                       neg_ff, neg_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic [nrsh_pkg::ProdW-1:0] acc_ff, acc_in, acc_sum;
   logic [nrsh_pkg::ProdW-1:0] prod_ff, prod_in;
   logic [nrsh_pkg::OpW+nrsh_pkg::DigitW-1:0] part;

   function automatic logic [nrsh_pkg::OpW-1:0] mag64(input logic signed [nrsh_pkg::OpW-1:0] v);
      mag64 = v[nrsh_pkg::OpW-1] ? (~v + 1'b1) : v;
   endfunction

   assign part = (nrsh_pkg::OpW+nrsh_pkg::DigitW)'(mag_a_ff)
               * (nrsh_pkg::OpW+nrsh_pkg::DigitW)'(mag_b_ff[nrsh_pkg::OpW-1 -: nrsh_pkg::DigitW]);
   assign acc_sum = (acc_ff << nrsh_pkg::DigitW) + nrsh_pkg::ProdW'(part);

   always_comb begin
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      if (req.start) begin
         mag_a_in = mag64(req.op_a);
         mag_b_in = mag64(req.op_b);
         neg_in   = req.op_a[nrsh_pkg::OpW-1] ^ req.op_b[nrsh_pkg::OpW-1];
         acc_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = acc_sum;
         mag_b_in = mag_b_ff << nrsh_pkg::DigitW;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(nrsh_pkg::Digits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            prod_in = neg_ff ? (~acc_sum + 1'b1) : acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
   end

   assign rsp = '{done: done_ff, prod: prod_ff};

endmodule

[sv/nearest_ray_sphere_hit.sv]
// Top level of the nearest ray/sphere hit block: sequencer, root and divide.
// Depends on nrsh_pkg, nrsh_if, nrsh_ram, nrsh_mul and assert_macros.svh.
//
// Usage:
//   req_chan carries one word per item. func = load writes center, diameter
//   and tint into entry slot (slots past the table are dropped).
//   func = trace tests the ray against the first sphere_count entries and
//   returns one word on rsp_chan: hit, distance, colour, point and normal,
//   all zero on a miss.
//   csr_chan writes sphere_count; write it only while no trace is in flight.
//   One word is worked on at a time. A trace searches each sphere in turn
//   with the shared 64x16 multiplier (12 products a sphere), the 60-step
//   square root and the 31-step divider (one or two divides a sphere); a
//   sphere that misses early skips the later steps, and a hit adds the
//   products for the hit point.
//   The result sits in an output register: the next item is taken while it
//   waits, and a later trace holds its result until the receiver takes the
//   previous one.
//   Reset clears sphere_count and the control state; table entries are
//   undefined until loaded.
`include "assert_macros.svh"

module nearest_ray_sphere_hit #(
   parameter int MAX_SPHERES = nrsh_pkg::MaxSpheres
) (
   input logic       clock,
   input logic       reset,
   nrsh_req_if.sink   req_chan,
   nrsh_rsp_if.source rsp_chan,
   nrsh_csr_if.sink   csr_chan
);

   localparam int IdxW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CntW = $clog2(MAX_SPHERES + 1);
   localparam int CW   = nrsh_pkg::CoordW;
   localparam int F    = nrsh_pkg::FracBits;
   localparam int DW   = nrsh_pkg::DistW;
   localparam int OW   = nrsh_pkg::OpW;
   localparam int PW   = nrsh_pkg::ProdW;
   localparam int SW   = nrsh_pkg::SumW;
   localparam int RtW  = nrsh_pkg::RootW;
   localparam int RdW  = nrsh_pkg::RadW;
   localparam int NumW = 96;
   localparam int DremW = 66;

   typedef enum logic [3:0] {
      PR_DD_X, PR_DD_Y, PR_DD_Z, PR_DK_X, PR_DK_Y, PR_DK_Z, PR_KK_X, PR_KK_Y,
      PR_KK_Z, PR_RR, PR_HH, PR_AC, PR_PT_X, PR_PT_Y, PR_PT_Z
   } prod_type;

   nrsh_pkg::state_type state_ff, state_in;
   prod_type            pidx_ff, pidx_in;

   logic [nrsh_pkg::CountW-1:0] sphere_count_ff, sphere_count_in;
   logic [CntW-1:0]             count_ff, count_in, idx_ff, idx_in, idx_next;
   logic [IdxW-1:0]             best_idx_ff, best_idx_in;
   logic                        found_ff, found_in;
   logic [DW-1:0]               best_t_ff, best_t_in, t_ff, t_in;
   logic                        mul_wait_ff, mul_wait_in;

   logic signed [CW-1:0] o_ff [3];
   logic signed [CW-1:0] o_in [3];
   logic signed [CW-1:0] d_ff [3];
   logic signed [CW-1:0] d_in [3];
   logic signed [CW-1:0] ctr_ff [3];
   logic signed [CW-1:0] ctr_in [3];
   logic signed [CW:0]   k_ff [3];
   logic signed [CW:0]   k_in [3];
   logic signed [CW-1:0] pt_ff [3];
   logic signed [CW-1:0] pt_in [3];
   logic signed [CW-1:0] nrm [3];
   logic [nrsh_pkg::DiamW-1:0] diam_ff, diam_in;
   logic [nrsh_pkg::TintW-1:0] colour_ff, colour_in;

   logic signed [SW-1:0] wa_ff, wa_in, wh_ff, wh_in, wk_ff, wk_in;
   logic signed [OW-1:0] a_ff, a_in, h_ff, h_in, c_ff, c_in;
   logic signed [PW-1:0] hh_ff, hh_in, disc_ff, disc_in;

   logic [RdW-1:0]   rad_ff, rad_in;
   logic [RtW-1:0]   root_ff, root_in;
   logic [RtW+1:0]   srem_ff, srem_in;
   logic [5:0]       sq_cnt_ff, sq_cnt_in;
   logic [RtW+3:0]   sq_rem2, sq_trial;

   logic signed [OW-1:0] n1_ff, n1_in, n0_ff, n0_in, root_s, div_num;
   logic                 div_second_ff, div_second_in;
   logic [DremW-1:0]     drem_ff, drem_in;
   logic [DW-1:0]        dlow_ff, dlow_in, q_ff, q_in;
   logic [4:0]           dcnt_ff, dcnt_in;
   logic [NumW-1:0]      div_numer;
   logic [DremW:0]       div_rem2;

   logic                 rsp_valid_ff, rsp_valid_in, rsp_load;
   logic                 hit_ff;
   logic [DW-1:0]        dist_ff;
   logic [nrsh_pkg::TintW-1:0] out_colour_ff;
   logic signed [CW-1:0] out_pt_ff [3];
   logic signed [CW-1:0] out_nrm_ff [3];

   logic                 ram_wr_en;
   logic [IdxW-1:0]      ram_wr_addr, ram_rd_addr;
   nrsh_pkg::entry_type  ram_wr_data, ram_rd_data;
   logic [$bits(nrsh_pkg::entry_type)-1:0] ram_rd_raw;

   nrsh_pkg::mul_req_type mul_req;
   nrsh_pkg::mul_rsp_type mul_rsp;
   logic                  mul_start;
   logic signed [OW-1:0]  mul_op_a, mul_op_b;

   logic req_fire;
   logic signed [OW-1:0] pt_sum;

   function automatic logic signed [CW-1:0] sat32(input logic signed [OW-1:0] v);
      if (v > $signed({{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}})) begin
         sat32 = {1'b0, {(CW-1){1'b1}}};
      end else if (v < $signed({{(OW-CW+1){1'b1}}, {(CW-1){1'b0}}})) begin
         sat32 = {1'b1, {(CW-1){1'b0}}};
      end else begin
         sat32 = CW'(v);
      end
   endfunction

   nrsh_ram #(
      .WIDTH  ($bits(nrsh_pkg::entry_type)),
      .DEPTH  (MAX_SPHERES),
      .ADDR_W (IdxW)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );
   assign ram_rd_data = nrsh_pkg::entry_type'(ram_rd_raw);

   assign mul_req = '{start: mul_start, op_a: mul_op_a, op_b: mul_op_b};

   nrsh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   assign req_chan.ready = (state_ff == nrsh_pkg::S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign ram_wr_en   = req_fire && (req_chan.func == nrsh_pkg::FUNC_LOAD)
                        && (9'(req_chan.slot) < 9'(MAX_SPHERES));
   assign ram_wr_addr = IdxW'(req_chan.slot);
   assign ram_wr_data = '{cx: req_chan.pos_x, cy: req_chan.pos_y, cz: req_chan.pos_z,
                          diameter: req_chan.diameter, tint: req_chan.tint};

   assign idx_next = idx_ff + 1'b1;

   // root step
   assign sq_rem2  = {srem_ff, rad_ff[RdW-1 -: 2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign root_s   = OW'({1'b0, root_ff});

   // divide: floor(n * 2^F / a), saturating
   assign div_num   = div_second_ff ? n0_ff : n1_ff;
   assign div_numer = NumW'($unsigned(div_num)) << F;
   assign div_rem2  = {drem_ff, dlow_ff[DW-1]};

   always_comb begin
      unique case (pidx_ff)
         PR_DD_X: begin mul_op_a = OW'(d_ff[0]); mul_op_b = OW'(d_ff[0]); end
         PR_DD_Y: begin mul_op_a = OW'(d_ff[1]); mul_op_b = OW'(d_ff[1]); end
         PR_DD_Z: begin mul_op_a = OW'(d_ff[2]); mul_op_b = OW'(d_ff[2]); end
         PR_DK_X: begin mul_op_a = OW'(d_ff[0]); mul_op_b = OW'(k_ff[0]); end
         PR_DK_Y: begin mul_op_a = OW'(d_ff[1]); mul_op_b = OW'(k_ff[1]); end
         PR_DK_Z: begin mul_op_a = OW'(d_ff[2]); mul_op_b = OW'(k_ff[2]); end
         PR_KK_X: begin mul_op_a = OW'(k_ff[0]); mul_op_b = OW'(k_ff[0]); end
         PR_KK_Y: begin mul_op_a = OW'(k_ff[1]); mul_op_b = OW'(k_ff[1]); end
         PR_KK_Z: begin mul_op_a = OW'(k_ff[2]); mul_op_b = OW'(k_ff[2]); end
         PR_RR:   begin mul_op_a = OW'(diam_ff);  mul_op_b = OW'(diam_ff);  end
         PR_HH:   begin mul_op_a = h_ff;          mul_op_b = h_ff;          end
         PR_AC:   begin mul_op_a = a_ff;          mul_op_b = c_ff;          end
         PR_PT_X: begin mul_op_a = OW'(d_ff[0]); mul_op_b = OW'(best_t_ff); end
         PR_PT_Y: begin mul_op_a = OW'(d_ff[1]); mul_op_b = OW'(best_t_ff); end
         PR_PT_Z: begin mul_op_a = OW'(d_ff[2]); mul_op_b = OW'(best_t_ff); end
         default: begin mul_op_a = '0;           mul_op_b = '0;           end
      endcase
   end

   assign pt_sum = OW'(o_ff[pidx_ff == PR_PT_X ? 0 : (pidx_ff == PR_PT_Y ? 1 : 2)])
                 + OW'(mul_rsp.prod >>> F);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         nrm[j] = sat32(OW'(pt_ff[j]) - OW'(ctr_ff[j]));
      end
   end

   always_comb begin
      state_in        = state_ff;
      pidx_in         = pidx_ff;
      sphere_count_in = sphere_count_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      best_idx_in     = best_idx_ff;
      found_in        = found_ff;
      best_t_in       = best_t_ff;
      t_in            = t_ff;
      mul_wait_in     = mul_wait_ff;
      o_in            = o_ff;
      d_in            = d_ff;
      ctr_in          = ctr_ff;
      k_in            = k_ff;
      pt_in           = pt_ff;
      diam_in         = diam_ff;
      colour_in       = colour_ff;
      wa_in           = wa_ff;
      wh_in           = wh_ff;
      wk_in           = wk_ff;
      a_in            = a_ff;
      h_in            = h_ff;
      c_in            = c_ff;
      hh_in           = hh_ff;
      disc_in         = disc_ff;
      rad_in          = rad_ff;
      root_in         = root_ff;
      srem_in         = srem_ff;
      sq_cnt_in       = sq_cnt_ff;
      n1_in           = n1_ff;
      n0_in           = n0_ff;
      div_second_in   = div_second_ff;
      drem_in         = drem_ff;
      dlow_in         = dlow_ff;
      q_in            = q_ff;
      dcnt_in         = dcnt_ff;
      rsp_load        = 1'b0;
      mul_start       = 1'b0;
      ram_rd_addr     = idx_ff[IdxW-1:0];

      if (csr_chan.valid) begin
         sphere_count_in = csr_chan.sphere_count;
      end

      unique case (state_ff)
         nrsh_pkg::S_IDLE: begin
            ram_rd_addr = '0;
            if (req_fire && req_chan.func == nrsh_pkg::FUNC_TRACE) begin
               o_in[0]  = req_chan.pos_x;
               o_in[1]  = req_chan.pos_y;
               o_in[2]  = req_chan.pos_z;
               d_in[0]  = req_chan.dir_x;
               d_in[1]  = req_chan.dir_y;
               d_in[2]  = req_chan.dir_z;
               found_in = 1'b0;
               idx_in   = '0;
               count_in = (9'(sphere_count_ff) > 9'(MAX_SPHERES)) ? CntW'(MAX_SPHERES)
                                                                 : CntW'(sphere_count_ff);
               if (count_in == '0) begin
                  state_in = nrsh_pkg::S_FINAL;
               end else begin
                  state_in = nrsh_pkg::S_READ;
               end
            end
         end
         nrsh_pkg::S_READ: begin
            ctr_in[0] = ram_rd_data.cx;
            ctr_in[1] = ram_rd_data.cy;
            ctr_in[2] = ram_rd_data.cz;
            diam_in   = ram_rd_data.diameter;
            k_in[0]   = (CW+1)'(o_ff[0]) - (CW+1)'(ram_rd_data.cx);
            k_in[1]   = (CW+1)'(o_ff[1]) - (CW+1)'(ram_rd_data.cy);
            k_in[2]   = (CW+1)'(o_ff[2]) - (CW+1)'(ram_rd_data.cz);
            wa_in     = '0;
            wh_in     = '0;
            wk_in     = '0;
            pidx_in   = PR_DD_X;
            state_in  = nrsh_pkg::S_MUL;
         end
         nrsh_pkg::S_MUL: begin
            if (!mul_wait_ff) begin
               mul_start   = 1'b1;
               mul_wait_in = 1'b1;
            end else if (mul_rsp.done) begin
               mul_wait_in = 1'b0;
               pidx_in     = prod_type'(4'(pidx_ff) + 4'd1);
               unique case (pidx_ff)
                  PR_DD_X, PR_DD_Y, PR_DD_Z: wa_in = wa_ff + SW'(mul_rsp.prod);
                  PR_DK_X, PR_DK_Y, PR_DK_Z: wh_in = wh_ff + SW'(mul_rsp.prod);
                  PR_KK_X, PR_KK_Y, PR_KK_Z: wk_in = wk_ff + SW'(mul_rsp.prod);
                  PR_RR: begin
                     wk_in    = (wk_ff <<< 2) - SW'(mul_rsp.prod);
                     state_in = nrsh_pkg::S_ABC;
                  end
                  PR_HH: hh_in = mul_rsp.prod;
                  PR_AC: begin
                     disc_in  = hh_ff - mul_rsp.prod;
                     state_in = nrsh_pkg::S_DISC;
                  end
                  PR_PT_X: pt_in[0] = sat32(pt_sum);
                  PR_PT_Y: pt_in[1] = sat32(pt_sum);
                  PR_PT_Z: begin
                     pt_in[2] = sat32(pt_sum);
                     state_in = nrsh_pkg::S_POST;
                  end
                  default: state_in = nrsh_pkg::S_IDLE;
               endcase
            end
         end
         nrsh_pkg::S_ABC: begin
            a_in = OW'(wa_ff >>> F);
            h_in = OW'(wh_ff >>> F);
            c_in = OW'(wk_ff >>> (F + 2));
            if (a_in <= 0) begin
               state_in = nrsh_pkg::S_NEXT;
            end else begin
               pidx_in  = PR_HH;
               state_in = nrsh_pkg::S_MUL;
            end
         end
         nrsh_pkg::S_DISC: begin
            rad_in    = disc_ff[RdW-1:0];
            root_in   = '0;
            srem_in   = '0;
            sq_cnt_in = 6'(RtW);
            if (disc_ff[PW-1]) begin
               state_in = nrsh_pkg::S_NEXT;
            end else begin
               state_in = nrsh_pkg::S_SQRT;
            end
         end
         nrsh_pkg::S_SQRT: begin
            rad_in    = rad_ff << 2;
            sq_cnt_in = sq_cnt_ff - 1'b1;
            if (sq_rem2 >= sq_trial) begin
               srem_in = (RtW+2)'(sq_rem2 - sq_trial);
               root_in = {root_ff[RtW-2:0], 1'b1};
            end else begin
               srem_in = (RtW+2)'(sq_rem2);
               root_in = {root_ff[RtW-2:0], 1'b0};
            end
            if (sq_cnt_ff == 6'd1) begin
               state_in = nrsh_pkg::S_ROOT;
            end
         end
         nrsh_pkg::S_ROOT: begin
            n1_in         = root_s - h_ff;
            n0_in         = -h_ff - root_s;
            div_second_in = 1'b0;
            if (n1_in <= 0) begin
               state_in = nrsh_pkg::S_NEXT;
            end else begin
               state_in = nrsh_pkg::S_DIVST;
            end
         end
         nrsh_pkg::S_DIVST: begin
            q_in    = '0;
            drem_in = DremW'(div_numer >> DW);
            dlow_in = div_numer[DW-1:0];
            dcnt_in = 5'(DW);
            if (div_numer >= (NumW'($unsigned(a_ff)) << DW)) begin
               q_in     = nrsh_pkg::DistMax;
               state_in = nrsh_pkg::S_DIVDONE;
            end else begin
               state_in = nrsh_pkg::S_DIV;
            end
         end
         nrsh_pkg::S_DIV: begin
            dlow_in = dlow_ff << 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (div_rem2 >= (DremW+1)'($unsigned(a_ff))) begin
               drem_in = DremW'(div_rem2 - (DremW+1)'($unsigned(a_ff)));
               q_in    = {q_ff[DW-2:0], 1'b1};
            end else begin
               drem_in = DremW'(div_rem2);
               q_in    = {q_ff[DW-2:0], 1'b0};
            end
            if (dcnt_ff == 5'd1) begin
               state_in = nrsh_pkg::S_DIVDONE;
            end
         end
         nrsh_pkg::S_DIVDONE: begin
            if (!div_second_ff) begin
               t_in = q_ff;
               if (q_ff == '0) begin
                  state_in = nrsh_pkg::S_NEXT;
               end else if (n0_ff > 0) begin
                  div_second_in = 1'b1;
                  state_in      = nrsh_pkg::S_DIVST;
               end else begin
                  state_in = nrsh_pkg::S_CMP;
               end
            end else begin
               if (q_ff != '0) begin
                  t_in = q_ff;
               end
               state_in = nrsh_pkg::S_CMP;
            end
         end
         nrsh_pkg::S_CMP: begin
            if (!found_ff || t_ff < best_t_ff) begin
               found_in    = 1'b1;
               best_t_in   = t_ff;
               best_idx_in = idx_ff[IdxW-1:0];
            end
            state_in = nrsh_pkg::S_NEXT;
         end
         nrsh_pkg::S_NEXT: begin
            ram_rd_addr = idx_next[IdxW-1:0];
            if (idx_next == count_ff) begin
               state_in = nrsh_pkg::S_FINAL;
            end else begin
               idx_in   = idx_next;
               state_in = nrsh_pkg::S_READ;
            end
         end
         nrsh_pkg::S_FINAL: begin
            ram_rd_addr = best_idx_ff;
            if (found_ff) begin
               state_in = nrsh_pkg::S_FRD;
            end else begin
               state_in = nrsh_pkg::S_OUT;
            end
         end
         nrsh_pkg::S_FRD: begin
            ctr_in[0] = ram_rd_data.cx;
            ctr_in[1] = ram_rd_data.cy;
            ctr_in[2] = ram_rd_data.cz;
            colour_in = ram_rd_data.tint;
            pidx_in   = PR_PT_X;
            state_in  = nrsh_pkg::S_MUL;
         end
         nrsh_pkg::S_POST: begin
            state_in = nrsh_pkg::S_OUT;
         end
         nrsh_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = nrsh_pkg::S_IDLE;
            end
         end
         default: state_in = nrsh_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= nrsh_pkg::S_IDLE;
         sphere_count_ff <= '0;
         found_ff        <= 1'b0;
         mul_wait_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sphere_count_ff <= sphere_count_in;
         found_ff        <= found_in;
         mul_wait_ff     <= mul_wait_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pidx_ff       <= pidx_in;
      count_ff      <= count_in;
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_t_ff     <= best_t_in;
      t_ff          <= t_in;
      o_ff          <= o_in;
      d_ff          <= d_in;
      ctr_ff        <= ctr_in;
      k_ff          <= k_in;
      pt_ff         <= pt_in;
      diam_ff       <= diam_in;
      colour_ff     <= colour_in;
      wa_ff         <= wa_in;
      wh_ff         <= wh_in;
      wk_ff         <= wk_in;
      a_ff          <= a_in;
      h_ff          <= h_in;
      c_ff          <= c_in;
      hh_ff         <= hh_in;
      disc_ff       <= disc_in;
      rad_ff        <= rad_in;
      root_ff       <= root_in;
      srem_ff       <= srem_in;
      sq_cnt_ff     <= sq_cnt_in;
      n1_ff         <= n1_in;
      n0_ff         <= n0_in;
      div_second_ff <= div_second_in;
      drem_ff       <= drem_in;
      dlow_ff       <= dlow_in;
      q_ff          <= q_in;
      dcnt_ff       <= dcnt_in;
      if (rsp_load) begin
         hit_ff        <= found_ff;
         dist_ff       <= found_ff ? best_t_ff : '0;
         out_colour_ff <= found_ff ? colour_ff : '0;
         for (int j = 0; j < 3; j++) begin
            out_pt_ff[j]  <= found_ff ? pt_ff[j] : '0;
            out_nrm_ff[j] <= found_ff ? nrm[j] : '0;
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = hit_ff;
   assign rsp_chan.hit_distance = dist_ff;
   assign rsp_chan.hit_colour   = out_colour_ff;
   assign rsp_chan.point_x      = out_pt_ff[0];
   assign rsp_chan.point_y      = out_pt_ff[1];
   assign rsp_chan.point_z      = out_pt_ff[2];
   assign rsp_chan.normal_x     = out_nrm_ff[0];
   assign rsp_chan.normal_y     = out_nrm_ff[1];
   assign rsp_chan.normal_z     = out_nrm_ff[2];

   `NRSH_ASSERT_IMP(a_mul_done_expected, mul_rsp.done, mul_wait_ff)
   `NRSH_ASSERT_IMP(a_best_in_range, found_ff, CntW'(best_idx_ff) < count_ff)
   `NRSH_ASSERT_NEXT(a_out_loaded, rsp_load, rsp_valid_ff && state_ff == nrsh_pkg::S_IDLE)

endmodule
